// ----- sv/assert_macros.svh -----
// Assertion macros shared by the mode arbiter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Clocked check, disabled while reset is low.
`define SMA_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("%m: check failed");

// Clocked check that also holds during reset.
`define SMA_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("%m: check failed");

`else

`define SMA_ASSERT(label, clk, rst_n, prop)

`define SMA_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

// ----- sv/sma_pkg.sv -----
// Types and constants shared by the system mode arbiter.
package sma_pkg;

    // Mode codes
    localparam logic [2:0] MODE_INIT      = 3'd0;
    localparam logic [2:0] MODE_NORMAL    = 3'd1;
    localparam logic [2:0] MODE_OTA       = 3'd2;
    localparam logic [2:0] MODE_FILE_UPD  = 3'd3;
    localparam logic [2:0] MODE_PROG      = 3'd4;
    localparam logic [2:0] MODE_TEST      = 3'd5;

    // Command codes
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_REQ   = 2'd1;
    localparam logic [1:0] CMD_FORCE = 2'd2;

    // Status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_BAD  = 2'd1;
    localparam logic [1:0] ST_BUSY = 2'd2;

    // Register map
    localparam int          ADDR_W           = 3;
    localparam logic        REG_TEST_TIMEOUT = 1'b0;
    localparam logic        REG_LONG_TIMEOUT = 1'b1;
    localparam logic [31:0] RESET_TIMEOUT_MS = 32'd1800000;

    typedef struct packed {
        logic [1:0] cmd;
        logic [2:0] wanted_mode;
        logic [7:0] priority_req;
    } t_item;

    typedef struct packed {
        logic [1:0] status;
        logic [2:0] current_mode;
        logic       switched;
    } t_result;

    typedef struct packed {
        logic [31:0] test_timeout_ms;
        logic [31:0] long_op_timeout_ms;
    } t_cfg;

endpackage

// ----- sv/sma_in_if.sv -----
// Input channel: one command per transfer.
interface sma_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic [2:0] wanted_mode;
    logic [7:0] priority_req;

    modport source (output valid, output cmd, output wanted_mode, output priority_req,
                    input ready);
    modport sink   (input valid, input cmd, input wanted_mode, input priority_req,
                    output ready);
endinterface

// ----- sv/sma_out_if.sv -----
// Result channel: one result per transfer.
interface sma_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [2:0] current_mode;
    logic       switched;

    modport source (output valid, output status, output current_mode, output switched,
                    input ready);
    modport sink   (input valid, input status, input current_mode, input switched,
                    output ready);
endinterface

// ----- sv/sma_regs.sv -----
// APB configuration registers for the timeout limits.
module sma_regs (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [sma_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    output sma_pkg::t_cfg             o_cfg
);

    logic [31:0] r_test_timeout;
    logic [31:0] r_long_timeout;
    logic        w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    // Write on the access cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_test_timeout <= sma_pkg::RESET_TIMEOUT_MS;
            r_long_timeout <= sma_pkg::RESET_TIMEOUT_MS;
        end else if (w_wr) begin
            if (paddr[2] == sma_pkg::REG_LONG_TIMEOUT) begin
                r_long_timeout <= pwdata;
            end else begin
                r_test_timeout <= pwdata;
            end
        end
    end

    // Read back
    assign prdata = (paddr[2] == sma_pkg::REG_LONG_TIMEOUT) ? r_long_timeout : r_test_timeout;

    assign o_cfg.test_timeout_ms    = r_test_timeout;
    assign o_cfg.long_op_timeout_ms = r_long_timeout;

endmodule

// ----- sv/sma_core.sv -----
// Mode state and the combinational decision for one command.
module sma_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  sma_pkg::t_item   i_item,
    input  sma_pkg::t_cfg    i_cfg,
    output sma_pkg::t_result o_res
);

    logic [2:0]  r_mode;
    logic [7:0]  r_owner_prio;
    logic        r_armed;
    logic [31:0] r_limit;
    logic [31:0] r_elapsed;

    logic [2:0]  n_mode;
    logic [7:0]  n_owner_prio;
    logic        n_armed;
    logic [31:0] n_limit;
    logic [31:0] n_elapsed;

    logic [1:0]  w_status;
    logic        w_changed;
    logic        w_enter;
    logic [2:0]  w_enter_mode;
    logic [31:0] w_elapsed_inc;
    logic        w_bad;
    logic        w_lreq;
    logic        w_lcur;

    assign w_elapsed_inc = (r_elapsed == '1) ? r_elapsed : r_elapsed + 32'd1;
    assign w_bad  = (i_item.wanted_mode > sma_pkg::MODE_TEST);
    assign w_lreq = (i_item.wanted_mode == sma_pkg::MODE_OTA) ||
                    (i_item.wanted_mode == sma_pkg::MODE_FILE_UPD) ||
                    (i_item.wanted_mode == sma_pkg::MODE_PROG);
    assign w_lcur = (r_mode == sma_pkg::MODE_OTA) ||
                    (r_mode == sma_pkg::MODE_FILE_UPD) ||
                    (r_mode == sma_pkg::MODE_PROG);

    // Decide status, whether a mode is entered, the owner priority and the elapsed count
    always_comb begin
        w_status     = sma_pkg::ST_OK;
        w_enter      = 1'b0;
        w_enter_mode = i_item.wanted_mode;
        n_owner_prio = r_owner_prio;
        n_elapsed    = r_elapsed;
        unique case (i_item.cmd)
            sma_pkg::CMD_TICK: begin
                n_elapsed = w_elapsed_inc;
                if (r_armed && (w_elapsed_inc >= r_limit)) begin
                    w_enter      = 1'b1;
                    w_enter_mode = sma_pkg::MODE_NORMAL;
                end
            end
            sma_pkg::CMD_REQ: begin
                priority if (w_bad) begin
                    w_status = sma_pkg::ST_BAD;
                end else if (i_item.wanted_mode == r_mode) begin
                    w_status = sma_pkg::ST_OK;
                end else if ((i_item.wanted_mode == sma_pkg::MODE_TEST) && w_lcur) begin
                    w_status = sma_pkg::ST_BUSY;
                end else if (w_lreq && (r_mode == sma_pkg::MODE_TEST)) begin
                    w_status = sma_pkg::ST_BUSY;
                end else if (w_lreq && w_lcur && (i_item.priority_req <= r_owner_prio)) begin
                    w_status = sma_pkg::ST_BUSY;
                end else begin
                    w_enter      = 1'b1;
                    n_owner_prio = i_item.priority_req;
                end
            end
            sma_pkg::CMD_FORCE: begin
                if (w_bad) begin
                    w_status = sma_pkg::ST_BAD;
                end else begin
                    w_enter = 1'b1;
                end
            end
            default: begin
                w_status = sma_pkg::ST_OK;
            end
        endcase
    end

    // Apply a mode entry: set the mode, arm or drop the timeout (elapsed time is cleared in the state register)
    always_comb begin
        n_mode    = r_mode;
        n_armed   = r_armed;
        n_limit   = r_limit;
        w_changed = w_enter;
        if (w_enter) begin
            n_mode = w_enter_mode;
            if (w_enter_mode == sma_pkg::MODE_TEST) begin
                n_armed = 1'b1;
                n_limit = i_cfg.test_timeout_ms;
            end else if ((w_enter_mode == sma_pkg::MODE_OTA) ||
                         (w_enter_mode == sma_pkg::MODE_FILE_UPD)) begin
                n_armed = 1'b1;
                n_limit = i_cfg.long_op_timeout_ms;
            end else begin
                n_armed = 1'b0;
            end
        end
    end

    // Advance state on each command
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= sma_pkg::MODE_INIT;
            r_owner_prio <= '0;
            r_armed      <= 1'b0;
            r_limit      <= '0;
            r_elapsed    <= '0;
        end else if (i_fire) begin
            r_mode       <= n_mode;
            r_owner_prio <= n_owner_prio;
            r_armed      <= n_armed;
            r_limit      <= n_limit;
            r_elapsed    <= w_enter ? '0 : n_elapsed;
        end
    end

    assign o_res.status       = w_status;
    assign o_res.current_mode = n_mode;
    assign o_res.switched     = w_changed;

endmodule

// ----- sv/system_mode_arbiter.sv -----
// Top level of the system mode arbiter: channels, pipeline registers, config port.
`include "assert_macros.svh"

// The arbiter takes one command per clock while results are taken and returns one result
// per command: the command lands in an input register, the mode decision is combinational
// and the state update is registered as the command leaves that register, and the result is
// held in an output register until it is taken. Sustained rate is one command per cycle
// while the result side stays ready; a stalled result only holds off new commands once the
// input register is also full. The two timeout registers are sampled when test, ota or
// file update mode is entered and should be written only while no command is in flight.
module system_mode_arbiter (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    sma_in_if.sink                     i_in,
    sma_out_if.source                  o_out,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [sma_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    logic             r_in_vld;
    sma_pkg::t_item   r_in_item;
    logic             r_out_vld;
    sma_pkg::t_result r_out_res;

    logic             w_adv;
    logic             w_fire;
    logic             w_in_xfer;
    sma_pkg::t_cfg    w_cfg;
    sma_pkg::t_result w_res;

    sma_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    sma_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_fire),
        .i_item  (r_in_item),
        .i_cfg   (w_cfg),
        .o_res   (w_res)
    );

    // Handshake control
    assign w_adv      = !r_out_vld || o_out.ready;
    assign w_fire     = r_in_vld && w_adv;
    assign i_in.ready = !r_in_vld || w_adv;
    assign w_in_xfer  = i_in.valid && i_in.ready;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (w_in_xfer) begin
            r_in_vld <= 1'b1;
        end else if (w_fire) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_in_item.cmd          <= i_in.cmd;
            r_in_item.wanted_mode  <= i_in.wanted_mode;
            r_in_item.priority_req <= i_in.priority_req;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_fire) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_res <= w_res;
        end
    end

    assign o_out.valid        = r_out_vld;
    assign o_out.status       = r_out_res.status;
    assign o_out.current_mode = r_out_res.current_mode;
    assign o_out.switched     = r_out_res.switched;

    // Checks
    `SMA_ASSERT(a_in_lands, i_clk, i_rst_n, w_in_xfer |=> r_in_vld)
    `SMA_ASSERT(a_fire_shows, i_clk, i_rst_n, w_fire |=> o_out.valid)
    `SMA_ASSERT(a_mode_legal, i_clk, i_rst_n, o_out.valid |-> (o_out.current_mode <= sma_pkg::MODE_TEST))
    `SMA_ASSERT(a_fail_no_change, i_clk, i_rst_n, (o_out.valid && (o_out.status != sma_pkg::ST_OK)) |-> !o_out.switched)
    `SMA_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> (!r_in_vld && !r_out_vld))

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for the system mode arbiter: directed table, then random phases.
`timescale 1ns / 1ps

module tb;

    // Codes outside the valid mode and command sets
    localparam logic [2:0] MODE_BAD_6 = 3'd6;
    localparam logic [2:0] MODE_BAD_7 = 3'd7;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // Byte addresses of the two timeout registers
    localparam logic [sma_pkg::ADDR_W-1:0] ADDR_TEST = {sma_pkg::REG_TEST_TIMEOUT, 2'b00};
    localparam logic [sma_pkg::ADDR_W-1:0] ADDR_LONG = {sma_pkg::REG_LONG_TIMEOUT, 2'b00};

    localparam int          CYCLE_LIMIT   = 200000;
    localparam int          PHASE_ITEMS   = 170;
    localparam int          PLAN_ROWS     = 25;
    localparam logic [5:0]  ANY_RES       = 6'd0;

    // One row of the directed plan: command, whether the result is typed in, the result
    typedef struct packed {
        sma_pkg::t_item   item;
        logic             typed;
        sma_pkg::t_result res;
    } t_row;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [sma_pkg::ADDR_W-1:0] paddr;
    logic [31:0]                pwdata;
    logic [31:0]                prdata;
    logic                       pready;

    sma_in_if  in_ch();
    sma_out_if out_ch();

    system_mode_arbiter dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 i_clk = ~i_clk;

    // Predicted arbiter state and register copies
    sma_pkg::t_cfg cfg      = '{test_timeout_ms: sma_pkg::RESET_TIMEOUT_MS,
                                long_op_timeout_ms: sma_pkg::RESET_TIMEOUT_MS};
    logic [2:0]  cur_mode   = sma_pkg::MODE_INIT;
    logic [7:0]  hold_prio  = 8'd0;
    logic        tmo_armed  = 1'b0;
    logic [31:0] tmo_limit  = 32'd0;
    logic [31:0] ms_elapsed = 32'd0;

    sma_pkg::t_result pending_results[$];

    int error_count    = 0;
    int items_sent     = 0;
    int results_seen   = 0;
    int fallback_count = 0;
    int busy_count     = 0;
    int bad_count      = 0;
    int cycle_count    = 0;

    // Directed plan: edge cases first, then busy rules, priorities and timeouts
    // (timeouts written to 2 for test and 3 for ota/file update before this runs)
    t_row plan [0:PLAN_ROWS-1] = '{
        {sma_pkg::CMD_TICK,  sma_pkg::MODE_INIT, 8'd0,
         1'b1, sma_pkg::ST_OK, sma_pkg::MODE_INIT, 1'b0},
        {sma_pkg::CMD_REQ,   MODE_BAD_6, 8'd50,
         1'b1, sma_pkg::ST_BAD, sma_pkg::MODE_INIT, 1'b0},
        {sma_pkg::CMD_FORCE, MODE_BAD_7, 8'd0,
         1'b1, sma_pkg::ST_BAD, sma_pkg::MODE_INIT, 1'b0},
        {CMD_UNUSED,         MODE_BAD_7, 8'd255,
         1'b1, sma_pkg::ST_OK, sma_pkg::MODE_INIT, 1'b0},
        {sma_pkg::CMD_REQ,   sma_pkg::MODE_INIT, 8'd50,
         1'b1, sma_pkg::ST_OK, sma_pkg::MODE_INIT, 1'b0},
        {sma_pkg::CMD_REQ,   sma_pkg::MODE_NORMAL,   8'd0,   1'b0, ANY_RES},
        {sma_pkg::CMD_REQ,   sma_pkg::MODE_OTA,      8'd0,   1'b0, ANY_RES},
        {sma_pkg::CMD_REQ,   sma_pkg::MODE_TEST, 8'd255,
         1'b1, sma_pkg::ST_BUSY, sma_pkg::MODE_OTA, 1'b0},
        {sma_pkg::CMD_REQ,   sma_pkg::MODE_FILE_UPD, 8'd0,   1'b0, ANY_RES},
        {sma_pkg::CMD_REQ,   sma_pkg::MODE_FILE_UPD, 8'd1,   1'b0, ANY_RES},
        {sma_pkg::CMD_TICK,  sma_pkg::MODE_INIT,     8'd0,   1'b0, ANY_RES},
        {sma_pkg::CMD_TICK,  sma_pkg::MODE_INIT,     8'd0,   1'b0, ANY_RES},
        {sma_pkg::CMD_TICK,  sma_pkg::MODE_INIT,     8'd0,   1'b0, ANY_RES},
        {sma_pkg::CMD_REQ,   sma_pkg::MODE_PROG,     8'd255, 1'b0, ANY_RES},
        {sma_pkg::CMD_REQ,   sma_pkg::MODE_OTA,      8'd255, 1'b0, ANY_RES},
        {sma_pkg::CMD_TICK,  sma_pkg::MODE_TEST,     8'd17,  1'b0, ANY_RES},
        {sma_pkg::CMD_REQ,   sma_pkg::MODE_TEST,     8'd7,   1'b0, ANY_RES},
        {sma_pkg::CMD_FORCE, sma_pkg::MODE_TEST,     8'd0,   1'b0, ANY_RES},
        {sma_pkg::CMD_REQ,   sma_pkg::MODE_OTA,      8'd255, 1'b0, ANY_RES},
        {sma_pkg::CMD_REQ,   sma_pkg::MODE_PROG,     8'd0,   1'b0, ANY_RES},
        {sma_pkg::CMD_FORCE, sma_pkg::MODE_TEST,     8'd255, 1'b0, ANY_RES},
        {sma_pkg::CMD_TICK,  sma_pkg::MODE_INIT,     8'd0,   1'b0, ANY_RES},
        {sma_pkg::CMD_TICK,  sma_pkg::MODE_INIT,     8'd0,   1'b0, ANY_RES},
        {sma_pkg::CMD_REQ,   MODE_BAD_7, 8'd255,
         1'b1, sma_pkg::ST_BAD, sma_pkg::MODE_NORMAL, 1'b0},
        {sma_pkg::CMD_FORCE, sma_pkg::MODE_INIT,     8'd0,   1'b0, ANY_RES}
    };

    task automatic flag_mismatch(input string what);
        $display("ERROR at %0t ns: %s", $time, what);
        error_count++;
    endtask

    function automatic logic is_long_mode(input logic [2:0] m);
        return m == sma_pkg::MODE_OTA || m == sma_pkg::MODE_FILE_UPD ||
               m == sma_pkg::MODE_PROG;
    endfunction

    // Set the mode, clear the elapsed count, arm the timeout where the mode has one
    function automatic void enter_mode(input logic [2:0] m);
        cur_mode   = m;
        ms_elapsed = 32'd0;
        if (m == sma_pkg::MODE_TEST) begin
            tmo_armed = 1'b1;
            tmo_limit = cfg.test_timeout_ms;
        end else if (m == sma_pkg::MODE_OTA || m == sma_pkg::MODE_FILE_UPD) begin
            tmo_armed = 1'b1;
            tmo_limit = cfg.long_op_timeout_ms;
        end else begin
            tmo_armed = 1'b0;
        end
    endfunction

    // Advance the predicted state by one command and return its result
    function automatic sma_pkg::t_result predict_mode(input sma_pkg::t_item it);
        sma_pkg::t_result r;
        logic             lreq;
        logic             lcur;
        r    = '0;
        lreq = is_long_mode(it.wanted_mode);
        lcur = is_long_mode(cur_mode);
        case (it.cmd)
            sma_pkg::CMD_TICK: begin
                if (ms_elapsed != 32'hFFFF_FFFF)
                    ms_elapsed = ms_elapsed + 32'd1;
                if (tmo_armed && ms_elapsed >= tmo_limit) begin
                    enter_mode(sma_pkg::MODE_NORMAL);
                    r.switched = 1'b1;
                    fallback_count++;
                end
            end
            sma_pkg::CMD_REQ: begin
                if (it.wanted_mode > sma_pkg::MODE_TEST) begin
                    r.status = sma_pkg::ST_BAD;
                    bad_count++;
                end else if (it.wanted_mode != cur_mode) begin
                    if ((it.wanted_mode == sma_pkg::MODE_TEST && lcur) ||
                        (lreq && cur_mode == sma_pkg::MODE_TEST) ||
                        (lreq && lcur && it.priority_req <= hold_prio)) begin
                        r.status = sma_pkg::ST_BUSY;
                        busy_count++;
                    end else begin
                        hold_prio = it.priority_req;
                        enter_mode(it.wanted_mode);
                        r.switched = 1'b1;
                    end
                end
            end
            sma_pkg::CMD_FORCE: begin
                if (it.wanted_mode > sma_pkg::MODE_TEST) begin
                    r.status = sma_pkg::ST_BAD;
                    bad_count++;
                end else begin
                    enter_mode(it.wanted_mode);
                    r.switched = 1'b1;
                end
            end
            default: ;
        endcase
        r.current_mode = cur_mode;
        return r;
    endfunction

    // Random command; priorities often sit on the owner's priority to hit the strict compare
    function automatic sma_pkg::t_item draw_item();
        sma_pkg::t_item it;
        int unsigned    roll;
        roll = $urandom_range(0, 99);
        if (roll < 48)
            it.cmd = sma_pkg::CMD_TICK;
        else if (roll < 78)
            it.cmd = sma_pkg::CMD_REQ;
        else if (roll < 94)
            it.cmd = sma_pkg::CMD_FORCE;
        else
            it.cmd = CMD_UNUSED;
        if ($urandom_range(0, 11) == 0)
            it.wanted_mode = 3'($urandom_range(MODE_BAD_6, MODE_BAD_7));
        else
            it.wanted_mode = 3'($urandom_range(sma_pkg::MODE_INIT, sma_pkg::MODE_TEST));
        case ($urandom_range(0, 3))
            0:       it.priority_req = hold_prio;
            1:       it.priority_req = hold_prio + 8'd1;
            2:       it.priority_req = hold_prio - 8'd1;
            default: it.priority_req = 8'($urandom_range(0, 255));
        endcase
        return it;
    endfunction

    // Drive one command after a random gap, record its expected result on transfer
    task automatic send_item(input sma_pkg::t_item it, input logic typed,
                             input sma_pkg::t_result typed_res);
        int               gap;
        sma_pkg::t_result predicted;
        gap = ((items_sent % 64) < 16) ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.cmd          <= it.cmd;
        in_ch.wanted_mode  <= it.wanted_mode;
        in_ch.priority_req <= it.priority_req;
        do @(posedge i_clk); while (!(in_ch.valid === 1'b1 && in_ch.ready === 1'b1));
        predicted = predict_mode(it);
        pending_results.push_back(typed ? typed_res : predicted);
        items_sent++;
    endtask

    // One APB transfer; on a read, compare the returned value with d
    task automatic apb_xfer(input logic wr, input logic [sma_pkg::ADDR_W-1:0] a,
                            input logic [31:0] d);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= a;
        pwdata  <= d;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        if (!wr && prdata !== d)
            flag_mismatch($sformatf("register 0x%0h read 0x%08h, want 0x%08h", a, prdata, d));
    endtask

    // Write both timeouts, read them back, release the bus
    task automatic set_timeouts(input logic [31:0] test_ms, input logic [31:0] long_ms);
        apb_xfer(1'b1, ADDR_TEST, test_ms);
        cfg.test_timeout_ms = test_ms;
        apb_xfer(1'b1, ADDR_LONG, long_ms);
        cfg.long_op_timeout_ms = long_ms;
        apb_xfer(1'b0, ADDR_TEST, test_ms);
        apb_xfer(1'b0, ADDR_LONG, long_ms);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Drop the input and hold until every expected result has been taken
    task automatic wait_results_drained();
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Result side: stall for a random count, then hold ready until a transfer
    initial begin : result_sink
        int stall;
        out_ch.ready <= 1'b0;
        do @(posedge i_clk); while (i_rst_n !== 1'b1);
        forever begin
            stall = ((results_seen % 48) < 12) ? 0 : $urandom_range(0, 16);
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(out_ch.valid === 1'b1 && out_ch.ready === 1'b1));
        end
    end

    // Compare each result transfer against the oldest expectation
    always @(posedge i_clk) begin
        sma_pkg::t_result got;
        sma_pkg::t_result want;
        if (i_rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            got = {out_ch.status, out_ch.current_mode, out_ch.switched};
            results_seen++;
            if (pending_results.size() == 0) begin
                flag_mismatch($sformatf("unexpected result %p", got));
            end else begin
                want = pending_results.pop_front();
                if (got.status !== want.status)
                    flag_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
                if (got.current_mode !== want.current_mode)
                    flag_mismatch($sformatf("mode %0d, want %0d",
                                            got.current_mode, want.current_mode));
                if (got.switched !== want.switched)
                    flag_mismatch($sformatf("changed %0b, want %0b",
                                            got.switched, want.switched));
            end
        end
    end

    // Hang guard
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results pending",
                 cycle_count, pending_results.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Main sequence: reset, register checks, directed plan, random phases
    initial begin : stimulus
        int ph;
        int k;
        int i;
        i_rst_n            <= 1'b0;
        psel               <= 1'b0;
        penable            <= 1'b0;
        pwrite             <= 1'b0;
        paddr              <= '0;
        pwdata             <= '0;
        in_ch.valid        <= 1'b0;
        in_ch.cmd          <= sma_pkg::CMD_TICK;
        in_ch.wanted_mode  <= sma_pkg::MODE_INIT;
        in_ch.priority_req <= 8'd0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset values of both registers, then the directed timeouts
        apb_xfer(1'b0, ADDR_TEST, sma_pkg::RESET_TIMEOUT_MS);
        apb_xfer(1'b0, ADDR_LONG, sma_pkg::RESET_TIMEOUT_MS);
        set_timeouts(32'd2, 32'd3);

        for (i = 0; i < PLAN_ROWS; i++)
            send_item(plan[i].item, plan[i].typed, plan[i].res);
        wait_results_drained();

        // Random phases, each under its own pair of timeouts
        for (ph = 0; ph < 5; ph++) begin
            case (ph)
                0:       set_timeouts(32'd1, 32'd1);
                1:       set_timeouts(32'd5, 32'd12);
                2:       set_timeouts(32'hFFFF_FFFF, 32'hFFFF_FFFF);
                3:       set_timeouts($urandom_range(1, 40), $urandom_range(1, 40));
                default: set_timeouts(32'd9, 32'd3);
            endcase
            for (k = 0; k < PHASE_ITEMS; k++) begin
                // hold off mid-phase until the pipeline is empty
                if (ph == 2 && k == PHASE_ITEMS / 2)
                    wait_results_drained();
                send_item(draw_item(), 1'b0, '0);
            end
            wait_results_drained();
        end
        in_ch.valid <= 1'b0;

        // Let any stray result show up before closing
        wait_results_drained();
        repeat (8) @(posedge i_clk);
        $display("run: %0d commands sent, %0d results checked, %0d errors",
                 items_sent, results_seen, error_count);
        $display("seen: %0d timeout fallbacks, %0d busy refusals, %0d bad mode values",
                 fallback_count, busy_count, bad_count);
        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ----- system_mode_arbiter.f -----
+incdir+sv
sv/sma_pkg.sv
sv/sma_in_if.sv
sv/sma_out_if.sv
sv/sma_regs.sv
sv/sma_core.sv
sv/system_mode_arbiter.sv
tb/tb.sv
